@@ src/sgm_pkg.sv @@
// Shared types and constants for the Sobel gradient magnitude block.
// No dependencies; used by the window stage, the magnitude stage and the top level.
package sgm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

	// register widths and reset values
	localparam int unsigned FW_BITS = 11;
	localparam int unsigned FH_BITS = 16;
	localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
	localparam logic [FH_BITS-1:0] FH_RESET = 16'd480;

	// smallest window dimension and saturation level
	localparam int unsigned MIN_DIM = 3;
	localparam int unsigned MAG_MAX = 255;

	// per-item control that rides along with the pixel
	typedef struct packed {
		logic emit;  // item completes an interior window
		logic last;  // interior pixel is the last of the frame
	} sgm_tag_t;

endpackage

@@ src/sgm_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read; read data holds when re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/sgm_window.sv @@
// 3x3 window registers and Sobel column/row weighted sums.
// Depends on sgm_pkg for the item tag type.
module sgm_window #(
	parameter int PB = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [PB-1:0]     top,
	input  logic [PB-1:0]     mid,
	input  logic [PB-1:0]     pix,
	input  sgm_pkg::sgm_tag_t tag_s1,
	output logic [PB+1:0]     right_s2,
	output logic [PB+1:0]     left_s2,
	output logic [PB+1:0]     upper_s2,
	output logic [PB+1:0]     lower_s2,
	output sgm_pkg::sgm_tag_t tag_s2
);

	localparam int SW = PB + 2;

	// columns c-2 (lt, lm, lb) and c-1 (ct, cm, cb)
	logic [PB-1:0] lt_q, lm_q, lb_q, ct_q, cm_q, cb_q;

	// shift the window by one column per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			lm_q <= '0;
			lb_q <= '0;
			ct_q <= '0;
			cm_q <= '0;
			cb_q <= '0;
		end else if (adv) begin
			lt_q <= ct_q;
			lm_q <= cm_q;
			lb_q <= cb_q;
			ct_q <= top;
			cm_q <= mid;
			cb_q <= pix;
		end
	end

	// weighted sums for Gx (right - left) and Gy (lower - upper)
	always_ff @(posedge clk) begin
		if (adv) begin
			right_s2 <= SW'(top) + {1'b0, mid, 1'b0} + SW'(pix);
			left_s2  <= SW'(lt_q) + {1'b0, lm_q, 1'b0} + SW'(lb_q);
			upper_s2 <= SW'(lt_q) + {1'b0, ct_q, 1'b0} + SW'(top);
			lower_s2 <= SW'(lb_q) + {1'b0, cb_q, 1'b0} + SW'(pix);
			tag_s2   <= tag_s1;
		end
	end

endmodule

@@ src/sgm_mag.sv @@
// Absolute differences, L1 sum and saturation into the output register.
// Depends on sgm_pkg for the saturation level.
module sgm_mag #(
	parameter int PB = 8
) (
	input  logic          clk,
	input  logic          load,
	input  logic [PB+1:0] right_s2,
	input  logic [PB+1:0] left_s2,
	input  logic [PB+1:0] upper_s2,
	input  logic [PB+1:0] lower_s2,
	input  logic          last_s2,
	output logic [7:0]    magnitude_q,
	output logic          last_q
);

	localparam int SW = PB + 2;

	logic [SW-1:0] gx_abs, gy_abs;
	logic [SW:0]   sum;
	logic          sat;

	// |Gx| + |Gy|, clipped to the 8-bit range
	always_comb begin
		gx_abs = (right_s2 >= left_s2) ? right_s2 - left_s2 : left_s2 - right_s2;
		gy_abs = (lower_s2 >= upper_s2) ? lower_s2 - upper_s2 : upper_s2 - lower_s2;
		sum    = {1'b0, gx_abs} + {1'b0, gy_abs};
		sat    = 16'(sum) > 16'(sgm_pkg::MAG_MAX);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			magnitude_q <= sat ? 8'(sgm_pkg::MAG_MAX) : 8'(sum);
			last_q      <= last_s2;
		end
	end

endmodule

@@ src/sobel_gradient_magnitude.sv @@
// Sobel 3x3 edge detector with saturated L1 gradient magnitude, streaming.
// Depends on sgm_pkg, sgm_ram, sgm_window and sgm_mag.
//
//  channel  direction  signals                         content
//  s_       in         s_tvalid s_tready s_tdata[7:0]  pixel
//  m_       out        m_tvalid m_tready m_tdata[7:0]  magnitude
//                      m_tlast                         last interior pixel of frame
//  cfg_     in         cfg_valid cfg_ready cfg_index   0: frame_width, 1: frame_height
//                      cfg_data[15:0]
//
// One pixel per cycle sustained while m_tready stays high; a taken pixel's result passes the
// line buffer read, the window sums and the magnitude register.
// Both line buffers share one address per item: read at accept, written back when the item
// leaves stage 1.
// Reset clears counters, window and valid flags; the line RAMs are not cleared.
// A stall on m_tready backs up through the stages and drops s_tready only when all are full.
module sobel_gradient_magnitude #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] magnitude
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EWM = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (EWM > int'(sgm_pkg::FW_BITS)) ? EWM : int'(sgm_pkg::FW_BITS);
	localparam int PB  = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
	localparam int FH  = sgm_pkg::FH_BITS;

	// configuration
	logic [sgm_pkg::FW_BITS-1:0] width_q;
	logic [FH-1:0]               height_q;

	// position of the next pixel
	logic [CW-1:0] col_q;
	logic [FH-1:0] row_q;

	// pipeline
	logic              valid_s1, valid_s2, m_tvalid_q;
	logic [PB-1:0]     pixel_s1;
	logic [CW-1:0]     col_s1;
	sgm_pkg::sgm_tag_t tag_s1, tag_s2, tag_in;
	logic [PB+1:0]     right_s2, left_s2, upper_s2, lower_s2;
	logic [PB-1:0]     top_rd, mid_rd;

	logic          accept, adv1, out_free, s2_free, load_out;
	logic [EW-1:0] fw_ext, eff_w, col_ext, col_inc;
	logic [FH-1:0] eff_h;
	logic [FH:0]   row_inc;

	assign cfg_ready = 1'b1;

	// take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sgm_pkg::FW_RESET;
			height_q <= sgm_pkg::FH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sgm_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data[sgm_pkg::FW_BITS-1:0];
				sgm_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp frame size and classify the incoming pixel
	always_comb begin
		fw_ext = EW'(width_q);
		if (fw_ext < EW'(sgm_pkg::MIN_DIM)) begin
			eff_w = EW'(sgm_pkg::MIN_DIM);
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = fw_ext;
		end
		eff_h   = (height_q < FH'(sgm_pkg::MIN_DIM)) ? FH'(sgm_pkg::MIN_DIM) : height_q;
		col_ext = EW'(col_q);
		col_inc = col_ext + EW'(1);
		row_inc = {1'b0, row_q} + (FH+1)'(1);
		tag_in.emit = (row_q >= FH'(2)) && (col_ext >= EW'(2))
			&& (row_q < eff_h) && (col_ext < eff_w);
		tag_in.last = (row_q == eff_h - FH'(1)) && (col_ext == eff_w - EW'(1));
	end

	// handshake and stage advance
	assign out_free = !m_tvalid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	assign adv1     = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign accept   = s_tvalid && s_tready;
	assign load_out = valid_s2 && out_free;

	// advance column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[FH-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// stage valid flags; items that complete no window drop out after stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= tag_s1.emit;
			end else if (load_out) begin
				valid_s2 <= 1'b0;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// hold the pixel while its line buffer read is in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= s_tdata[PB-1:0];
			col_s1   <= col_q;
			tag_s1   <= tag_in;
		end
	end

	// line buffers: upper takes the old middle entry, middle takes the new pixel
	sgm_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_line_upper (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (top_rd)
	);

	sgm_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_line_middle (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	sgm_window #(.PB(PB)) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv1),
		.top      (top_rd),
		.mid      (mid_rd),
		.pix      (pixel_s1),
		.tag_s1   (tag_s1),
		.right_s2 (right_s2),
		.left_s2  (left_s2),
		.upper_s2 (upper_s2),
		.lower_s2 (lower_s2),
		.tag_s2   (tag_s2)
	);

	sgm_mag #(.PB(PB)) u_mag (
		.clk         (clk),
		.load        (load_out),
		.right_s2    (right_s2),
		.left_s2     (left_s2),
		.upper_s2    (upper_s2),
		.lower_s2    (lower_s2),
		.last_s2     (tag_s2.last),
		.magnitude_q (m_tdata),
		.last_q      (m_tlast)
	);

	assign m_tvalid = m_tvalid_q;

	// input back-pressure only when stage 1 holds an item
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("s_tready low with stage 1 empty");

	// a pending window result is kept until the output register takes it
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_free) |=> valid_s2)
		else $error("stage 2 result lost under stall");

	// line buffer write-back never collides with the read of the next item
	a_rmw_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && accept) |-> (col_s1 != col_q))
		else $error("line buffer read and write at the same column");

	// a new output item comes only from a valid stage 2 result
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(valid_s2))
		else $error("output valid without stage 2 result");

endmodule

@@ tb/tb_sobel_gradient_magnitude.sv @@
// Self-checking testbench for sobel_gradient_magnitude: pixel frames in, L1 Sobel magnitudes out.
// Depends on sgm_pkg and the RTL; a cycle-free frame predictor gives every untyped result.
module tb_sobel_gradient_magnitude;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_W          = 1024;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned REPORT_LIMIT   = 10;
	// index that maps to no register; writes to it must change nothing
	localparam logic [1:0]  REG_UNUSED     = 2'd3;

	typedef struct packed {
		logic [7:0] mag;
		logic       last;
	} gradient_t;

	typedef struct packed {
		logic [7:0] pix;
		logic       typed;  // use res below instead of the predictor's result
		gradient_t  res;
	} stim_row_t;

	typedef enum int {PIX_NOISE, PIX_RAMP, PIX_BINARY} pix_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;      // [7:0] pixel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [7:0] magnitude
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int unsigned send_gap_pct = 32;
	int unsigned recv_stall_pct = 69;
	int unsigned fail_count = 0;
	int unsigned stall_cycles = 0;

	// predictor state
	logic [sgm_pkg::FW_BITS-1:0] cur_width = sgm_pkg::FW_RESET;
	logic [sgm_pkg::FH_BITS-1:0] cur_height = sgm_pkg::FH_RESET;
	bit [7:0]           line_upper [MAX_W];
	bit [7:0]           line_middle [MAX_W];
	bit [7:0]           win [6];
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	gradient_t          pending_grads [$];

	stim_row_t directed_rows [27];

	sobel_gradient_magnitude dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// randomly stall the result side
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int unsigned eff_width();
		if (cur_width < sgm_pkg::MIN_DIM) return sgm_pkg::MIN_DIM;
		if (cur_width > MAX_W) return MAX_W;
		return cur_width;
	endfunction

	function automatic int unsigned eff_height();
		return (cur_height < sgm_pkg::MIN_DIM) ? sgm_pkg::MIN_DIM : cur_height;
	endfunction

	// advance the frame position by one pixel; return 1 when an interior window completes
	function automatic bit sobel_predict(input logic [7:0] pix, output gradient_t res);
		int unsigned w, h, top, mid, right_sum, left_sum, upper_sum, lower_sum, total;
		bit emits;
		w = eff_width();
		h = eff_height();
		top = 0;
		mid = 0;
		emits = 1'b0;
		res = '0;
		if (col_pos < MAX_W) begin
			top = line_upper[col_pos];
			mid = line_middle[col_pos];
			line_upper[col_pos] = mid[7:0];
			line_middle[col_pos] = pix;
		end
		if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
			right_sum = top + 2 * mid + pix;
			left_sum = win[0] + 2 * win[1] + win[2];
			upper_sum = win[0] + 2 * win[3] + top;
			lower_sum = win[2] + 2 * win[5] + pix;
			total = ((right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum)
				+ ((lower_sum >= upper_sum) ? lower_sum - upper_sum : upper_sum - lower_sum);
			if (total > sgm_pkg::MAG_MAX) total = sgm_pkg::MAG_MAX;
			res.mag = total[7:0];
			res.last = (row_pos == h - 1 && col_pos == w - 1);
			emits = 1'b1;
		end
		// shift the window one column left
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = top[7:0];
		win[4] = mid[7:0];
		win[5] = pix;
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return emits;
	endfunction

	// offer one pixel after a random gap; hold it until taken, then predict
	task automatic send_pixel(input logic [7:0] pix, input logic typed, input gradient_t typed_res);
		gradient_t res;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		if (sobel_predict(pix, res)) pending_grads.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	task automatic send_pixels(input int unsigned count, input pix_pattern_t pattern);
		int unsigned base;
		logic [7:0] pix;
		base = $urandom_range(240);
		repeat (count) begin
			case (pattern)
				PIX_RAMP:   pix = 8'(base + $urandom_range(15));
				PIX_BINARY: pix = $urandom_range(1) ? 8'd255 : 8'd0;
				default:    pix = 8'($urandom_range(255));
			endcase
			send_pixel(pix, 1'b0, '0);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sgm_pkg::REG_FRAME_WIDTH:  cur_width = val[sgm_pkg::FW_BITS-1:0];
			sgm_pkg::REG_FRAME_HEIGHT: cur_height = val[sgm_pkg::FH_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending, drain every expected result, then let the pipeline empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_grads.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// whole frames with random geometry, mostly small, some clamped
	task automatic random_frames(input int unsigned budget);
		int unsigned sent, w_raw, h_raw, npix;
		logic [4:0] spare_bits;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(9))
				0:       w_raw = $urandom_range(2);
				1:       w_raw = $urandom_range(48, 11);
				default: w_raw = $urandom_range(10, 3);
			endcase
			case ($urandom_range(9))
				0:       h_raw = $urandom_range(2);
				1:       h_raw = $urandom_range(12, 7);
				default: h_raw = $urandom_range(6, 3);
			endcase
			spare_bits = 5'($urandom_range(31));
			wait_idle();
			write_reg(sgm_pkg::REG_FRAME_WIDTH, {spare_bits, w_raw[10:0]});
			write_reg(sgm_pkg::REG_FRAME_HEIGHT, h_raw[15:0]);
			npix = eff_width() * eff_height();
			repeat ($urandom_range(2, 1)) begin
				send_pixels(npix, pix_pattern_t'($urandom_range(2)));
				sent += npix;
			end
		end
	endtask

	// check results in order and watch for a hung handshake
	always @(posedge clk) begin
		gradient_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grads.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result: magnitude %0d last %0b", m_tdata, m_tlast);
			end else begin
				want = pending_grads.pop_front();
				if (m_tdata !== want.mag || m_tlast !== want.last) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("mismatch: expected magnitude %0d last %0b, got %0d last %0b",
							want.mag, want.last, m_tdata, m_tlast);
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else if (arst_n)
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// flat field, vertical step edge, then a mixed window on 3x3 frames
		directed_rows = '{
			'{8'd255, 1'b0, '{8'd0, 1'b0}}, '{8'd255, 1'b0, '{8'd0, 1'b0}},
			'{8'd255, 1'b0, '{8'd0, 1'b0}}, '{8'd255, 1'b0, '{8'd0, 1'b0}},
			'{8'd255, 1'b0, '{8'd0, 1'b0}}, '{8'd255, 1'b0, '{8'd0, 1'b0}},
			'{8'd255, 1'b0, '{8'd0, 1'b0}}, '{8'd255, 1'b0, '{8'd0, 1'b0}},
			'{8'd255, 1'b1, '{8'd0, 1'b1}},
			'{8'd0, 1'b0, '{8'd0, 1'b0}}, '{8'd0, 1'b0, '{8'd0, 1'b0}},
			'{8'd255, 1'b0, '{8'd0, 1'b0}},
			'{8'd0, 1'b0, '{8'd0, 1'b0}}, '{8'd0, 1'b0, '{8'd0, 1'b0}},
			'{8'd255, 1'b0, '{8'd0, 1'b0}},
			'{8'd0, 1'b0, '{8'd0, 1'b0}}, '{8'd0, 1'b0, '{8'd0, 1'b0}},
			'{8'd255, 1'b1, '{8'd255, 1'b1}},
			'{8'd200, 1'b0, '{8'd0, 1'b0}}, '{8'd100, 1'b0, '{8'd0, 1'b0}},
			'{8'd50, 1'b0, '{8'd0, 1'b0}},
			'{8'd0, 1'b0, '{8'd0, 1'b0}}, '{8'd0, 1'b0, '{8'd0, 1'b0}},
			'{8'd0, 1'b0, '{8'd0, 1'b0}},
			'{8'd7, 1'b0, '{8'd0, 1'b0}}, '{8'd9, 1'b0, '{8'd0, 1'b0}},
			'{8'd11, 1'b0, '{8'd0, 1'b0}}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames, smallest geometry
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 16'd3);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 16'd3);
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].res);

		random_frames(250);

		// tallest frame, then shrink width and height while inside it
		wait_idle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 16'd6);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
		send_pixels(22, PIX_NOISE);
		wait_idle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 16'd0);
		send_pixels(4, PIX_RAMP);
		wait_idle();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 16'd2);
		send_pixels(3, PIX_NOISE);

		// swap the idling sides
		wait_idle();
		send_gap_pct = 69;
		recv_stall_pct = 32;
		random_frames(250);

		// largest width value, then narrow the frame inside its first row
		wait_idle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 16'h07FF);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 16'd3);
		send_pixels(5, PIX_RAMP);
		wait_idle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 16'd3);
		send_pixels(7, PIX_NOISE);

		// full rate on both sides
		wait_idle();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		random_frames(250);

		wait_idle();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/sgm_pkg.sv
src/sgm_ram.sv
src/sgm_window.sv
src/sgm_mag.sv
src/sobel_gradient_magnitude.sv
tb/tb_sobel_gradient_magnitude.sv
